FILE: rtl/ffpea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpea_pkg: shared types and constants for the first-fit extent allocator
// Item formats, cell control and chain types, state and status codes.
// ----------------------------------------------------------------------------
package ffpea_pkg;

  localparam int FFPEA_FREE_EXTENTS = 64;
  localparam int ADDR_W             = 20;
  localparam int COUNT_W            = 21;
  localparam int STATUS_W           = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  page_addr;
    logic [COUNT_W-1:0] page_count;
  } ffpea_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_page;
  } ffpea_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [COUNT_W-1:0] length;
  } ffpea_ext_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FREE,
    OP_ALLOC
  } ffpea_op_t;

  typedef struct packed {
    logic               cmp_en;
    logic [COUNT_W-1:0] cmp_want;
    ffpea_op_t          op;
    logic [COUNT_W-1:0] want;
  } ffpea_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic              rm;
    logic [ADDR_W-1:0] grant;
  } ffpea_link_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } ffpea_state_t;

endpackage
`default_nettype wire

FILE: rtl/ffpea_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpea_cell: one slot of the free extent list
// Holds one extent, compares it against a request, trims it, or shifts in
// from a neighbor on push and exact-fit removal.
// ----------------------------------------------------------------------------
module ffpea_cell (
  input  logic                  clk,
  input  logic                  occ,
  input  ffpea_pkg::ffpea_ctrl_t ctrl,
  input  ffpea_pkg::ffpea_ext_t  prev_ext,
  input  ffpea_pkg::ffpea_ext_t  next_ext,
  input  ffpea_pkg::ffpea_link_t link_in,
  output ffpea_pkg::ffpea_link_t link_out,
  output ffpea_pkg::ffpea_ext_t  ext
);
  import ffpea_pkg::*;

  ffpea_ext_t ext_r;
  logic       fit_r;
  logic       exact_r;
  logic       first;

  assign first = fit_r & ~link_in.hit;
  assign ext   = ext_r;

  always_comb begin
    link_out.hit   = link_in.hit | fit_r;
    link_out.rm    = link_in.rm | (first & exact_r);
    link_out.grant = first ? ext_r.start : link_in.grant;
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      fit_r   <= occ && (ext_r.length >= ctrl.cmp_want);
      exact_r <= (ext_r.length == ctrl.cmp_want);
    end
    case (ctrl.op)
      OP_FREE: begin
        ext_r <= prev_ext;
      end
      OP_ALLOC: begin
        if (link_out.rm) begin
          ext_r <= next_ext;
        end else if (first) begin
          ext_r.start  <= ext_r.start + ctrl.want[ADDR_W-1:0];
          ext_r.length <= ext_r.length - ctrl.want;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/first_fit_page_extent_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_extent_allocator: first-fit free list of page extents
// Allocate takes the first extent large enough, trimming it from the low end
// or removing it on exact fit; free pushes an extent to the front if not full.
//
// Usage:
//   in_valid/in_stall/in_data carry requests (kind, page_addr, page_count).
//   out_valid/out_stall/out_data carry one result per request
//   (status, granted_page).
//   The accept edge registers the request and every cell compares its length
//   in parallel; in the update state the first fit is resolved along the
//   cell chain, the list is updated and the result register is loaded.
//   One item is in flight at a time; in_stall is high while in the update
//   state. A new item is accepted while the previous result waits.
//   When out_stall holds a result, the next update waits until it is taken.
//   Reset empties the list and drops any pending result; the extent
//   contents themselves are not cleared.
// ----------------------------------------------------------------------------
module first_fit_page_extent_allocator #(
  parameter int FREE_EXTENTS = ffpea_pkg::FFPEA_FREE_EXTENTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffpea_pkg::ffpea_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffpea_pkg::ffpea_out_t out_data
);
  import ffpea_pkg::*;

  localparam int CNT_W = $clog2(FREE_EXTENTS + 1);

  ffpea_state_t      state_r;
  ffpea_state_t      state_nxt;
  ffpea_in_t         req_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  used_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  ffpea_out_t        out_data_r;
  ffpea_out_t        out_data_nxt;
  logic              accept;
  logic              apply_go;
  logic              full;
  ffpea_ctrl_t       ctrl;
  ffpea_ext_t        push_ext;
  ffpea_ext_t        ext [FREE_EXTENTS];
  ffpea_link_t       link [FREE_EXTENTS+1];
  logic [FREE_EXTENTS-1:0] occ;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign apply_go  = (state_r == S_APPLY) & (~out_valid_r | ~out_stall);
  assign full      = (used_r == CNT_W'(FREE_EXTENTS));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign link[0]   = '0;

  always_comb begin
    push_ext.start  = req_r.page_addr;
    push_ext.length = req_r.page_count;
  end

  generate
    for (genvar i = 0; i < FREE_EXTENTS; i++) begin : g_cell
      ffpea_ext_t prev_ext;
      ffpea_ext_t next_ext;
      assign occ[i] = (CNT_W'(i) < used_r);
      if (i == 0) begin : g_head
        assign prev_ext = push_ext;
      end else begin : g_body
        assign prev_ext = ext[i-1];
      end
      if (i == FREE_EXTENTS - 1) begin : g_tail
        assign next_ext = '0;
      end else begin : g_mid
        assign next_ext = ext[i+1];
      end
      ffpea_cell u_cell (
        .clk      (clk),
        .occ      (occ[i]),
        .ctrl     (ctrl),
        .prev_ext (prev_ext),
        .next_ext (next_ext),
        .link_in  (link[i]),
        .link_out (link[i+1]),
        .ext      (ext[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl.cmp_en   = accept;
    ctrl.cmp_want = in_data.page_count;
    ctrl.op       = OP_HOLD;
    ctrl.want     = req_r.page_count;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (req_r.kind == KIND_FREE) begin
            out_data_nxt.granted_page = '0;
            if (full) begin
              out_data_nxt.status = STAT_FULL;
            end else begin
              ctrl.op             = OP_FREE;
              used_nxt            = used_r + 1'b1;
              out_data_nxt.status = STAT_DONE;
            end
          end else begin
            ctrl.op                   = OP_ALLOC;
            out_data_nxt.granted_page = link[FREE_EXTENTS].grant;
            out_data_nxt.status       = link[FREE_EXTENTS].hit ? STAT_DONE : STAT_NO_FIT;
            if (link[FREE_EXTENTS].rm) begin
              used_nxt = used_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      req_r <= in_data;
    end
  end

endmodule
`default_nettype wire
